### rtl/bslp_pkg.sv
// ----------------------------------------------------------------------------
// bslp_pkg
// Types and constants shared by the button short/long press detector files.
// ----------------------------------------------------------------------------
package bslp_pkg;

   localparam int unsigned DURATION_BITS  = 16;
   localparam int unsigned TICK_IN_BITS   = 32;
   localparam int unsigned CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LONG_PRESS_MS       = 1'b0,
      CSR_RELEASE_DEBOUNCE_MS = 1'b1
   } csr_index_type;

   localparam logic [DURATION_BITS-1:0] LONG_PRESS_RESET       = 16'd1000;
   localparam logic [DURATION_BITS-1:0] RELEASE_DEBOUNCE_RESET = 16'd50;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRESSED   = 3'd1,
      PH_REL_DEB   = 3'd2,
      PH_WAIT_LONG = 3'd3,
      PH_LONG_DEB  = 3'd4
   } phase_type;

   typedef struct packed {
      logic [TICK_IN_BITS-1:0] tick_now;
      logic                    press_event;
      logic                    button_down;
      logic                    take_short;
      logic                    take_long;
   } req_item_type;

   typedef struct packed {
      logic       short_press;
      logic       long_press;
      logic [2:0] gesture_state;
   } rsp_item_type;

   typedef struct packed {
      phase_type phase;
      logic      short_flag;
      logic      long_flag;
   } flags_type;

   typedef struct packed {
      logic [DURATION_BITS-1:0] long_press_ms;
      logic [DURATION_BITS-1:0] release_debounce_ms;
   } cfg_type;

endpackage

### rtl/bslp_if.sv
// ----------------------------------------------------------------------------
// bslp_if
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bslp_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

### rtl/bslp_csr.sv
// ----------------------------------------------------------------------------
// bslp_csr
// Configuration registers for hold time and release debounce time.
// ----------------------------------------------------------------------------
module bslp_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [bslp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bslp_pkg::DURATION_BITS-1:0]     csr_wdata,
   output bslp_pkg::cfg_type                      cfg
);
   import bslp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_LONG_PRESS_MS: begin
               cfg_in.long_press_ms = csr_wdata;
            end
            CSR_RELEASE_DEBOUNCE_MS: begin
               cfg_in.release_debounce_ms = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms       <= LONG_PRESS_RESET;
         cfg_ff.release_debounce_ms <= RELEASE_DEBOUNCE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/bslp_step.sv
// ----------------------------------------------------------------------------
// bslp_step
// Gesture state machine step: elapsed-time compares, next state and result.
// ----------------------------------------------------------------------------
module bslp_step #(
   parameter int unsigned TICK_BITS = 32
) (
   input  bslp_pkg::req_item_type   item,
   input  bslp_pkg::flags_type      flags,
   input  logic [TICK_BITS-1:0]     press_start,
   input  logic [TICK_BITS-1:0]     release_start,
   input  bslp_pkg::cfg_type        cfg,
   output bslp_pkg::flags_type      flags_next,
   output logic [TICK_BITS-1:0]     press_start_next,
   output logic [TICK_BITS-1:0]     release_start_next,
   output bslp_pkg::rsp_item_type   rsp
);
   import bslp_pkg::*;

   logic [TICK_BITS-1:0] now;
   logic [TICK_BITS-1:0] press_elapsed;
   logic [TICK_BITS-1:0] release_elapsed;
   logic                 long_done;
   logic                 debounce_done;
   flags_type            stepped;

   assign now             = TICK_BITS'(item.tick_now);
   assign press_elapsed   = now - press_start;
   assign release_elapsed = now - release_start;
   assign long_done       = press_elapsed >= TICK_BITS'(cfg.long_press_ms);
   assign debounce_done   = release_elapsed >= TICK_BITS'(cfg.release_debounce_ms);

   always_comb begin
      stepped            = flags;
      press_start_next   = press_start;
      release_start_next = release_start;
      case (flags.phase)
         PH_IDLE: begin
            if (item.press_event && item.button_down) begin
               press_start_next = now;
               stepped.phase    = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!item.button_down) begin
               release_start_next = now;
               stepped.phase      = PH_REL_DEB;
            end else if (long_done) begin
               stepped.long_flag = 1'b1;
               stepped.phase     = PH_WAIT_LONG;
            end
         end
         PH_REL_DEB: begin
            if (item.button_down) begin
               stepped.phase = PH_PRESSED;
            end else if (debounce_done) begin
               stepped.short_flag = 1'b1;
               stepped.phase      = PH_IDLE;
            end
         end
         PH_WAIT_LONG: begin
            if (!item.button_down) begin
               release_start_next = now;
               stepped.phase      = PH_LONG_DEB;
            end
         end
         PH_LONG_DEB: begin
            if (item.button_down) begin
               stepped.phase = PH_WAIT_LONG;
            end else if (debounce_done) begin
               stepped.phase = PH_IDLE;
            end
         end
         default: begin
            stepped.phase = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp.short_press   = stepped.short_flag;
      rsp.long_press    = stepped.long_flag;
      rsp.gesture_state = stepped.phase;
      flags_next        = stepped;
      if (item.take_short) begin
         flags_next.short_flag = 1'b0;
      end
      if (item.take_long) begin
         flags_next.long_flag = 1'b0;
      end
   end

endmodule

### rtl/button_short_long_press_detector_top.sv
// ----------------------------------------------------------------------------
// button_short_long_press_detector_top
// Detects short and long button presses from timestamped service calls.
//
//   Channel  Direction  Signals
//   req_bus  in         valid, ready, payload (tick_now, press_event,
//                       button_down, take_short, take_long)
//   rsp_bus  out        valid, ready, payload (short_press, long_press,
//                       gesture_state)
//   csr_*    in         csr_we, csr_index, csr_wdata
//
// One item per cycle is sustained while rsp_bus is not stalled. A request
// transfer lands in the input register; when the result register can take
// it, the state machine step updates the gesture state and loads the result
// register. Reset returns the state to idle and the durations to their
// defaults. A stalled result register holds the step; the input register
// still takes one more transfer.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_top #(
   parameter int unsigned TICK_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   bslp_if.sink                                req_bus,
   bslp_if.source                              rsp_bus,
   input  logic                                csr_we,
   input  logic [bslp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bslp_pkg::DURATION_BITS-1:0]  csr_wdata
);
   import bslp_pkg::*;

   cfg_type              cfg;
   logic                 req_valid_ff;
   req_item_type         req_item_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_item_ff;
   flags_type            flags_ff;
   flags_type            flags_in;
   logic [TICK_BITS-1:0] press_start_ff;
   logic [TICK_BITS-1:0] press_start_in;
   logic [TICK_BITS-1:0] release_start_ff;
   logic [TICK_BITS-1:0] release_start_in;
   rsp_item_type         rsp_item_in;
   logic                 advance;
   logic                 req_take;

   bslp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bslp_step #(
      .TICK_BITS (TICK_BITS)
   ) u_step (
      .item               (req_item_ff),
      .flags              (flags_ff),
      .press_start        (press_start_ff),
      .release_start      (release_start_ff),
      .cfg                (cfg),
      .flags_next         (flags_in),
      .press_start_next   (press_start_in),
      .release_start_next (release_start_in),
      .rsp                (rsp_item_in)
   );

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !req_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         flags_ff.phase   <= PH_IDLE;
         flags_ff.short_flag <= 1'b0;
         flags_ff.long_flag  <= 1'b0;
         press_start_ff   <= '0;
         release_start_ff <= '0;
      end else begin
         if (req_bus.ready) begin
            req_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            rsp_valid_ff     <= 1'b1;
            flags_ff         <= flags_in;
            press_start_ff   <= press_start_in;
            release_start_ff <= release_start_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_bus.payload;
      end
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_item_ff;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button short/long press detector. Timed
// service calls, made mostly of press gestures with bounces and some random
// noise, are sent over a range of hold and debounce times. Each result
// transfer is checked against a cycle-free model of the gesture state.
// ----------------------------------------------------------------------------
module tb;
   import bslp_pkg::*;

   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned PHASE_CALLS = 180;
   localparam int unsigned NUM_SETTINGS = 9;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   req_item_type  req_payload = '0;
   logic          rsp_ready = 1'b0;
   logic          csr_we = 1'b0;
   csr_index_type csr_index = CSR_LONG_PRESS_MS;
   logic [DURATION_BITS-1:0] csr_wdata = '0;

   bslp_if #(.payload_type(req_item_type)) req_if ();
   bslp_if #(.payload_type(rsp_item_type)) rsp_if ();

   assign req_if.valid   = req_valid;
   assign req_if.payload = req_payload;
   assign rsp_if.ready   = rsp_ready;

   button_short_long_press_detector_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_if),
      .rsp_bus  (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gesture model state and durations.
   phase_type                gest_phase = PH_IDLE;
   logic [TICK_IN_BITS-1:0]  press_t0 = '0;
   logic [TICK_IN_BITS-1:0]  release_t0 = '0;
   logic                     short_seen = 1'b0;
   logic                     long_seen = 1'b0;
   logic [DURATION_BITS-1:0] hold_ms = LONG_PRESS_RESET;
   logic [DURATION_BITS-1:0] debounce_ms = RELEASE_DEBOUNCE_RESET;

   req_item_type calls[$];
   rsp_item_type flags_due[$];

   int unsigned errors = 0;
   int unsigned quiet_cycles = 0;
   int unsigned calls_made = 0;
   logic [TICK_IN_BITS-1:0] now_ms = '0;

   logic        req_taken = 1'b0;
   logic        req_idle_on = 1'b0;
   logic        rsp_idle_on = 1'b0;
   int unsigned req_gap = 0;
   int unsigned rsp_gap = 0;
   int unsigned hold_req = 0;
   int unsigned hold_seen = 0;

   function automatic logic span_elapsed(logic [TICK_IN_BITS-1:0] now,
                                         logic [TICK_IN_BITS-1:0] start,
                                         logic [DURATION_BITS-1:0] span);
      logic [TICK_IN_BITS-1:0] gone;
      gone = now - start;
      return gone >= TICK_IN_BITS'(span);
   endfunction

   function automatic rsp_item_type step_gesture(req_item_type call);
      rsp_item_type res;
      case (gest_phase)
         PH_IDLE: begin
            if (call.press_event && call.button_down) begin
               press_t0 = call.tick_now;
               gest_phase = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            if (!call.button_down) begin
               release_t0 = call.tick_now;
               gest_phase = PH_REL_DEB;
            end else if (span_elapsed(call.tick_now, press_t0, hold_ms)) begin
               long_seen = 1'b1;
               gest_phase = PH_WAIT_LONG;
            end
         end
         PH_REL_DEB: begin
            if (call.button_down) begin
               gest_phase = PH_PRESSED;
            end else if (span_elapsed(call.tick_now, release_t0, debounce_ms)) begin
               short_seen = 1'b1;
               gest_phase = PH_IDLE;
            end
         end
         PH_WAIT_LONG: begin
            if (!call.button_down) begin
               release_t0 = call.tick_now;
               gest_phase = PH_LONG_DEB;
            end
         end
         PH_LONG_DEB: begin
            if (call.button_down) begin
               gest_phase = PH_WAIT_LONG;
            end else if (span_elapsed(call.tick_now, release_t0, debounce_ms)) begin
               gest_phase = PH_IDLE;
            end
         end
         default: gest_phase = PH_IDLE;
      endcase
      res.short_press = short_seen;
      res.long_press = long_seen;
      res.gesture_state = gest_phase;
      if (call.take_short) short_seen = 1'b0;
      if (call.take_long) long_seen = 1'b0;
      return res;
   endfunction

   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string what, logic [2:0] got, logic [2:0] want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic add_call(logic [TICK_IN_BITS-1:0] t, logic ev, logic dn,
                           logic ts, logic tl);
      req_item_type c;
      c.tick_now = t;
      c.press_event = ev;
      c.button_down = dn;
      c.take_short = ts;
      c.take_long = tl;
      calls.push_back(c);
      calls_made++;
   endtask

   task automatic add_timed(int unsigned span, logic ev, logic dn);
      now_ms = now_ms + $urandom_range(0, span);
      add_call(now_ms, ev, dn, $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
   endtask

   task automatic add_gesture(int unsigned span);
      int unsigned hold_n;
      int unsigned rel_n;
      hold_n = $urandom_range(0, 16);
      rel_n = $urandom_range(1, 8);
      add_timed(span, 1'b1, 1'b1);
      repeat (hold_n) add_timed(span, 1'($urandom_range(0, 1)), 1'b1);
      repeat (rel_n) add_timed(span, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
      repeat ($urandom_range(0, 3)) add_timed(span, 1'($urandom_range(0, 1)), 1'b0);
   endtask

   task automatic write_csr(csr_index_type idx, logic [DURATION_BITS-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LONG_PRESS_MS:       hold_ms = value;
         CSR_RELEASE_DEBOUNCE_MS: debounce_ms = value;
         default: ;
      endcase
   endtask

   task automatic settle();
      wait (calls.size() == 0 && flags_due.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (calls.size() > 0) begin
            req_valid <= 1'b1;
            req_payload <= calls[0];
            if (req_idle_on && $urandom_range(0, 3) == 0) req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         rsp_gap = 120;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_idle_on && $urandom_range(0, 4) == 0) rsp_gap = pick_gap();
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      logic rsp_taken;
      if (reset) begin
         req_taken = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_valid && req_if.ready;
         rsp_taken = rsp_if.valid && rsp_ready;
         if (rsp_taken) begin
            got = rsp_if.payload;
            if (flags_due.size() == 0) begin
               $display("%0t: result transfer with no result pending", $realtime);
               errors++;
            end else begin
               want = flags_due.pop_front();
               if (got.short_press !== want.short_press)
                  report_mismatch("short_press", {2'b00, got.short_press},
                                  {2'b00, want.short_press});
               if (got.long_press !== want.long_press)
                  report_mismatch("long_press", {2'b00, got.long_press},
                                  {2'b00, want.long_press});
               if (got.gesture_state !== want.gesture_state)
                  report_mismatch("gesture_state", got.gesture_state, want.gesture_state);
            end
         end
         if (req_taken) flags_due.push_back(step_gesture(calls.pop_front()));
         quiet_cycles = (req_taken || rsp_taken) ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [DURATION_BITS-1:0] long_set [NUM_SETTINGS];
      logic [DURATION_BITS-1:0] deb_set [NUM_SETTINGS];
      int unsigned span;
      int unsigned target;
      long_set = '{16'd20, 16'd1000, 16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0,
                   16'd300, 16'd0};
      deb_set = '{16'd5, 16'd50, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd3,
                  16'd40, 16'd0};
      long_set[NUM_SETTINGS-1] = DURATION_BITS'($urandom_range(1, 65535));
      deb_set[NUM_SETTINGS-1] = DURATION_BITS'($urandom_range(0, 65535));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default durations: ignored events, wrap of the press time, long
      // press with a bounce, short press with a bounce, same-step takes.
      add_call(32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0001, 1'b0, 1'b1, 1'b0, 1'b0);
      add_call(32'hFFFF_FF00, 1'b1, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_02E7, 1'b1, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_02E8, 1'b0, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0300, 1'b1, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0305, 1'b0, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0310, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0341, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0342, 1'b0, 1'b0, 1'b0, 1'b1);
      add_call(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0009, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_000A, 1'b0, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0014, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0046, 1'b0, 1'b0, 1'b1, 1'b1);
      add_call(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b1);
      settle();

      // Zero hold and debounce times take effect on the first step.
      write_csr(CSR_LONG_PRESS_MS, 16'd0);
      write_csr(CSR_RELEASE_DEBOUNCE_MS, 16'd0);
      @(posedge clock);
      add_call(32'h0000_0005, 1'b1, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0005, 1'b0, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0005, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0005, 1'b0, 1'b0, 1'b0, 1'b1);
      add_call(32'h0000_0006, 1'b1, 1'b1, 1'b0, 1'b0);
      add_call(32'h0000_0006, 1'b0, 1'b0, 1'b0, 1'b0);
      add_call(32'h0000_0006, 1'b0, 1'b0, 1'b1, 1'b0);
      settle();

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         write_csr(CSR_LONG_PRESS_MS, long_set[p]);
         write_csr(CSR_RELEASE_DEBOUNCE_MS, deb_set[p]);
         @(posedge clock);
         req_idle_on = (p % 3) != 0;
         rsp_idle_on = (p % 2) != 0;
         span = ((long_set[p] > deb_set[p]) ? long_set[p] : deb_set[p]) / 4 + 1;
         now_ms = ($urandom_range(0, 1) == 0) ? $urandom : 32'hFFFF_FFFF - span * 20;
         target = calls_made + PHASE_CALLS;
         while (calls_made < target) begin
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 3))
                  add_call($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               add_gesture(span);
            end
         end
         if (p == 2) begin
            // The result side stalls while calls keep coming, so the block
            // backs up and holds off its input.
            repeat (30) @(posedge clock);
            hold_req++;
         end
         settle();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
